// ===== hw/rtl/prd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the priority runway dispatcher: payload types, event codes,
// register addresses, sequencer states and saturating helpers.
// No dependencies.
package prd_pkg;

  typedef struct packed {
    logic [3:0] landing_arrivals;
    logic [3:0] takeoff_arrivals;
    logic       input_done;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  runway_number;
    logic [15:0] plane_number;
    logic [15:0] wait_ticks;
    logic [15:0] tick_time;
    logic [31:0] busy_total;
    logic [31:0] landing_wait_total;
    logic [31:0] takeoff_wait_total;
    logic [15:0] landing_planes;
    logic [15:0] takeoff_planes;
    logic        queue_overflow;
    logic        last;
  } out_t;

  // Status of one arrival queue
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  localparam logic [2:0] EV_TICK     = 3'd0;
  localparam logic [2:0] EV_FREED    = 3'd1;
  localparam logic [2:0] EV_LANDING  = 3'd2;
  localparam logic [2:0] EV_TAKEOFF  = 3'd3;
  localparam logic [2:0] EV_FINISHED = 3'd4;
  localparam logic [2:0] EV_BUSY     = 3'd5;

  localparam logic [1:0] REG_RUNWAY_COUNT = 2'd0;
  localparam logic [1:0] REG_LANDING_DUR  = 2'd1;
  localparam logic [1:0] REG_TAKEOFF_DUR  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ,
    S_TICK,
    S_FREE,
    S_DECIDE,
    S_FIN,
    S_BUSY,
    S_DREAD,
    S_DASSIGN,
    S_FLUSH
  } state_t;

  function automatic logic [15:0] sat16_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? 16'hFFFF : v + 16'd1;
  endfunction

  function automatic logic [31:0] sat32_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== hw/rtl/prd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the runway dispatcher.
// Depends on prd_pkg for the payload types.
interface prd_in_if (input logic clk);
  prd_pkg::in_t data;
  logic         valid;
  logic         ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prd_out_if (input logic clk);
  prd_pkg::out_t data;
  logic          valid;
  logic          ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/priority_runway_dispatcher_top.sv =====
`timescale 1ns / 1ps
// Top level of the priority runway dispatcher: APB register file, tick
// sequencer, runway state and result staging. Depends on prd_pkg, prd_if, prd_queue.
//
// Usage:
//   in_ch carries one tick per transaction (landing and takeoff arrival
//   counts, end-of-input flag). out_ch carries the events of that tick, the
//   final one flagged with last. Registers runway_count, landing_duration and
//   takeoff_duration sit at byte addresses 0, 4 and 8 of the APB port and
//   are to be written while the block is idle; the block does not enforce it.
//   in_ch.ready is high only in the idle state; one tick is worked on at a
//   time. Arrivals are queued one at a time at the queue write port, then
//   one pass over the runways counts down, and assignment takes a read
//   state and an assign state per runway, set by the registered read of the
//   queue head. The finish tick replaces the assignment pass by a state for
//   the finished event and a pass over the runways for totals.
//   Results move through a one-entry staging register and an output
//   register; a stalled receiver holds the sequencer, nothing is dropped.
//   Reset clears all counters, runways and queue pointers; the queue memory
//   itself is not cleared. After the finish tick, ticks are taken and
//   produce no results.
module priority_runway_dispatcher_top #(
  parameter int MAX_RUNWAYS = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  prd_in_if.sink      in_ch,
  prd_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import prd_pkg::*;

  localparam int IW = (MAX_RUNWAYS > 1) ? $clog2(MAX_RUNWAYS) : 1;
  localparam int RW = $clog2(MAX_RUNWAYS + 1);

  state_t state_r, state_nxt;

  logic [3:0] runway_count_r;
  logic [7:0] landing_dur_r, takeoff_dur_r;

  logic [7:0]  rem_r  [MAX_RUNWAYS];
  logic [7:0]  rem_nxt[MAX_RUNWAYS];
  logic [31:0] busy_r  [MAX_RUNWAYS];
  logic [31:0] busy_nxt[MAX_RUNWAYS];

  logic [15:0] tick_r, tick_nxt;
  logic [15:0] l_issued_r, l_issued_nxt, t_issued_r, t_issued_nxt;
  logic [15:0] l_served_r, l_served_nxt, t_served_r, t_served_nxt;
  logic [31:0] l_wsum_r, l_wsum_nxt, t_wsum_r, t_wsum_nxt;
  logic        ended_r, ended_nxt, ovf_r, ovf_nxt, finished_r, finished_nxt;
  logic        all_idle_r, all_idle_nxt;
  logic [3:0]  l_left_r, l_left_nxt, t_left_r, t_left_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  logic        pend_valid_r;
  out_t        pend_r;
  logic        out_valid_r;
  out_t        out_data_r;
  out_t        out_data_nxt;

  logic        in_acc, go, idx_last, fin_cond;
  logic        emit_en, flush_en, out_load;
  out_t        emit_d;
  logic [RW-1:0] rc;
  logic [15:0] l_head, t_head, wait_v;
  logic        l_push, t_push, l_pop, t_pop;
  q_stat_t     l_stat, t_stat;
  logic        cfg_wr;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      runway_count_r <= 4'd1;
      landing_dur_r  <= 8'd1;
      takeoff_dur_r  <= 8'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RUNWAY_COUNT: runway_count_r <= pwdata[3:0];
        REG_LANDING_DUR:  landing_dur_r  <= pwdata[7:0];
        REG_TAKEOFF_DUR:  takeoff_dur_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RUNWAY_COUNT: prdata = {28'd0, runway_count_r};
      REG_LANDING_DUR:  prdata = {24'd0, landing_dur_r};
      REG_TAKEOFF_DUR:  prdata = {24'd0, takeoff_dur_r};
      default:          prdata = '0;
    endcase
  end

  // Clamp runway count to 1..MAX_RUNWAYS
  always_comb begin
    if (runway_count_r == 4'd0) begin
      rc = RW'(1);
    end else if (int'(runway_count_r) > MAX_RUNWAYS) begin
      rc = RW'(MAX_RUNWAYS);
    end else begin
      rc = RW'(runway_count_r);
    end
  end

  assign idx_last = (int'(idx_r) == int'(rc) - 1);
  assign go       = !out_valid_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign fin_cond = ended_r && l_stat.empty && t_stat.empty && all_idle_r;

  // Arrival queues
  prd_queue #(.DEPTH(QUEUE_DEPTH)) u_land_q (
    .clk(clk), .rst_n(rst_n), .push(l_push), .push_data(tick_r),
    .pop(l_pop), .head_data(l_head), .stat(l_stat)
  );

  prd_queue #(.DEPTH(QUEUE_DEPTH)) u_take_q (
    .clk(clk), .rst_n(rst_n), .push(t_push), .push_data(tick_r),
    .pop(t_pop), .head_data(t_head), .stat(t_stat)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_acc) state_nxt = finished_r ? S_IDLE : S_ENQ;
      S_ENQ:     if (l_left_r == 4'd0 && t_left_r == 4'd0) state_nxt = S_TICK;
      S_TICK:    if (go) state_nxt = S_FREE;
      S_FREE:    if (go && idx_last) state_nxt = S_DECIDE;
      S_DECIDE:  state_nxt = fin_cond ? S_FIN : S_DREAD;
      S_FIN:     if (go) state_nxt = S_BUSY;
      S_BUSY:    if (go && idx_last) state_nxt = S_FLUSH;
      S_DREAD:   state_nxt = S_DASSIGN;
      S_DASSIGN: if (go) state_nxt = idx_last ? S_FLUSH : S_DREAD;
      S_FLUSH:   if (go) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and event generation
  always_comb begin
    rem_nxt      = rem_r;
    busy_nxt     = busy_r;
    tick_nxt     = tick_r;
    l_issued_nxt = l_issued_r;
    t_issued_nxt = t_issued_r;
    l_served_nxt = l_served_r;
    t_served_nxt = t_served_r;
    l_wsum_nxt   = l_wsum_r;
    t_wsum_nxt   = t_wsum_r;
    ended_nxt    = ended_r;
    ovf_nxt      = ovf_r;
    finished_nxt = finished_r;
    all_idle_nxt = all_idle_r;
    l_left_nxt   = l_left_r;
    t_left_nxt   = t_left_r;
    idx_nxt      = idx_r;
    l_push = 1'b0;
    t_push = 1'b0;
    l_pop  = 1'b0;
    t_pop  = 1'b0;
    emit_en  = 1'b0;
    flush_en = 1'b0;
    wait_v   = '0;
    emit_d   = '0;
    emit_d.tick_time = tick_r;
    unique case (state_r)
      S_IDLE: begin
        l_left_nxt = '0;
        t_left_nxt = '0;
        if (in_acc && !finished_r && !ended_r) begin
          if (in_ch.data.input_done) begin
            ended_nxt = 1'b1;
          end else begin
            l_left_nxt = in_ch.data.landing_arrivals;
            t_left_nxt = in_ch.data.takeoff_arrivals;
          end
        end
      end
      // Queue one arrival per cycle, landings first
      S_ENQ: begin
        if (l_left_r != 4'd0) begin
          l_left_nxt = l_left_r - 4'd1;
          if (l_stat.full) begin
            ovf_nxt = 1'b1;
          end else begin
            l_push = 1'b1;
            l_issued_nxt = sat16_inc(l_issued_r);
          end
        end else if (t_left_r != 4'd0) begin
          t_left_nxt = t_left_r - 4'd1;
          if (t_stat.full) begin
            ovf_nxt = 1'b1;
          end else begin
            t_push = 1'b1;
            t_issued_nxt = sat16_inc(t_issued_r);
          end
        end
      end
      S_TICK: begin
        idx_nxt      = '0;
        all_idle_nxt = 1'b1;
        if (go) begin
          emit_en = 1'b1;
          emit_d.event_kind = EV_TICK;
        end
      end
      // Count down one runway per cycle unless the output stalls
      S_FREE: begin
        if (go) begin
          if (rem_r[idx_r] != 8'd0) begin
            rem_nxt[idx_r] = rem_r[idx_r] - 8'd1;
            if (rem_r[idx_r] == 8'd1) begin
              emit_en = 1'b1;
              emit_d.event_kind    = EV_FREED;
              emit_d.runway_number = 4'(int'(idx_r) + 1);
            end else begin
              all_idle_nxt = 1'b0;
            end
          end
          if (!idx_last) idx_nxt = idx_r + IW'(1);
        end
      end
      S_DECIDE: begin
        idx_nxt = '0;
      end
      S_FIN: begin
        if (go) begin
          emit_en = 1'b1;
          emit_d.event_kind         = EV_FINISHED;
          emit_d.landing_wait_total = l_wsum_r;
          emit_d.takeoff_wait_total = t_wsum_r;
        end
      end
      S_BUSY: begin
        if (go) begin
          emit_en = 1'b1;
          emit_d.event_kind    = EV_BUSY;
          emit_d.runway_number = 4'(int'(idx_r) + 1);
          emit_d.busy_total    = busy_r[idx_r];
          if (idx_last) begin
            finished_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      S_DREAD: ;
      // Give a free runway the landing head, else the takeoff head
      S_DASSIGN: begin
        if (go) begin
          if (rem_r[idx_r] == 8'd0) begin
            if (!l_stat.empty) begin
              wait_v = tick_r - l_head;
              l_pop  = 1'b1;
              emit_en = 1'b1;
              emit_d.event_kind    = EV_LANDING;
              emit_d.runway_number = 4'(int'(idx_r) + 1);
              emit_d.wait_ticks    = wait_v;
              emit_d.plane_number  = (l_issued_r == 16'hFFFF && l_served_r >= 16'hFFFE)
                                     ? 16'hFFFF : sat16_inc(l_served_r);
              l_served_nxt   = sat16_inc(l_served_r);
              l_wsum_nxt     = sat32_add(l_wsum_r, {16'd0, wait_v});
              rem_nxt[idx_r] = landing_dur_r;
              busy_nxt[idx_r] = sat32_add(busy_r[idx_r], {24'd0, landing_dur_r});
            end else if (!t_stat.empty) begin
              wait_v = tick_r - t_head;
              t_pop  = 1'b1;
              emit_en = 1'b1;
              emit_d.event_kind    = EV_TAKEOFF;
              emit_d.runway_number = 4'(int'(idx_r) + 1);
              emit_d.wait_ticks    = wait_v;
              emit_d.plane_number  = sat16_inc(t_served_r);
              t_served_nxt   = sat16_inc(t_served_r);
              t_wsum_nxt     = sat32_add(t_wsum_r, {16'd0, wait_v});
              rem_nxt[idx_r] = takeoff_dur_r;
              busy_nxt[idx_r] = sat32_add(busy_r[idx_r], {24'd0, takeoff_dur_r});
            end
          end
          if (idx_last) begin
            tick_nxt = sat16_inc(tick_r);
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (go) flush_en = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_load = (emit_en && pend_valid_r) || flush_en;

  // Control and runway state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      for (int i = 0; i < MAX_RUNWAYS; i++) begin
        rem_r[i]  <= '0;
        busy_r[i] <= '0;
      end
      tick_r       <= '0;
      l_issued_r   <= '0;
      t_issued_r   <= '0;
      l_served_r   <= '0;
      t_served_r   <= '0;
      l_wsum_r     <= '0;
      t_wsum_r     <= '0;
      ended_r      <= 1'b0;
      ovf_r        <= 1'b0;
      finished_r   <= 1'b0;
      all_idle_r   <= 1'b1;
      l_left_r     <= '0;
      t_left_r     <= '0;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rem_r        <= rem_nxt;
      busy_r       <= busy_nxt;
      tick_r       <= tick_nxt;
      l_issued_r   <= l_issued_nxt;
      t_issued_r   <= t_issued_nxt;
      l_served_r   <= l_served_nxt;
      t_served_r   <= t_served_nxt;
      l_wsum_r     <= l_wsum_nxt;
      t_wsum_r     <= t_wsum_nxt;
      ended_r      <= ended_nxt;
      ovf_r        <= ovf_nxt;
      finished_r   <= finished_nxt;
      all_idle_r   <= all_idle_nxt;
      l_left_r     <= l_left_nxt;
      t_left_r     <= t_left_nxt;
      idx_r        <= idx_nxt;
      if (emit_en) begin
        pend_valid_r <= 1'b1;
      end else if (flush_en) begin
        pend_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Merge status into the staged event; status is final once arrivals are queued
  always_comb begin
    out_data_nxt                = pend_r;
    out_data_nxt.landing_planes = l_issued_r;
    out_data_nxt.takeoff_planes = t_issued_r;
    out_data_nxt.queue_overflow = ovf_r;
    out_data_nxt.last           = flush_en;
  end

  // Staging and output payload
  always_ff @(posedge clk) begin
    if (emit_en) begin
      pend_r <= emit_d;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Staging register is drained before the next tick is taken
  a_idle_pend_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_valid_r)
    else $error("staged result left over in idle");

  // No assignment work after the finish totals
  a_no_assign_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DASSIGN |-> !finished_r)
    else $error("assignment after finish");

  // Queue status is consistent
  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(l_stat.empty && l_stat.full) && !(t_stat.empty && t_stat.full))
    else $error("queue both empty and full");

  // A result is only pushed out when the output register is free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("output overwritten while stalled");

endmodule

// ===== hw/rtl/prd_queue.sv =====
`timescale 1ns / 1ps
// Circular arrival queue: memory of arrival ticks with head and fill count.
// Read data is registered from the head entry. Depends on prd_pkg.
module prd_queue #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [15:0]      push_data,
  input  logic             pop,
  output logic [15:0]      head_data,
  output prd_pkg::q_stat_t stat
);
  import prd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [15:0]   mem [DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW:0]   wr_sum;
  logic [AW-1:0] wr_addr;
  logic [15:0]   rd_data_r;

  // Tail address wraps once at most
  always_comb begin
    wr_sum = FW'(head_r) + fill_r;
    if (wr_sum >= (FW+1)'(DEPTH)) begin
      wr_addr = AW'(wr_sum - (FW+1)'(DEPTH));
    end else begin
      wr_addr = AW'(wr_sum);
    end
  end

  // Advance head and fill
  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (pop) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      fill_nxt = fill_r - FW'(1);
    end else if (push) begin
      fill_nxt = fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Memory write and registered head read
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_addr] <= push_data;
    end
    rd_data_r <= mem[head_r];
  end

  assign head_data  = rd_data_r;
  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FW'(DEPTH));

endmodule
